FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away when NO_ASSERTIONS
// is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ASSERT_SYNC(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_SYNC(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

FILE: hdl/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// Types and constants shared by the sort engine's cells and its top level.
// ----------------------------------------------------------------------------
package hse_pkg;

    // Width of one element.
    localparam int VALUE_W = 32;

    // One input item: an element and the end-of-set mark.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value_res;
        logic                      last_res;
        logic                      overflow;
    } t_out_item;

    // Commands broadcast to every cell of the row.
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

    // Phases of the engine.
    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } t_state;

endpackage

FILE: hdl/hse_cell.sv
// ----------------------------------------------------------------------------
// hse_cell
// One slot of the sorted row. On insert it keeps its element, takes the new
// element or takes its left neighbour's element; on shift it takes its right
// neighbour's element.
// ----------------------------------------------------------------------------
module hse_cell
    import hse_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctrl                i_ctrl,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_prev_keep,
    input  logic                      i_prev_valid,
    input  logic signed [VALUE_W-1:0] i_prev_value,
    input  logic                      i_next_valid,
    input  logic signed [VALUE_W-1:0] i_next_value,
    output logic                      o_keep,
    output logic                      o_valid,
    output logic signed [VALUE_W-1:0] o_value
);

    logic                      r_valid;
    logic                      n_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;

    // A held element stays put when it is not greater than the new one.
    assign o_keep  = r_valid && !(r_value > i_value);
    assign o_valid = r_valid;
    assign o_value = r_value;

    // Next contents of the slot.
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.insert) begin
            if (!o_keep) begin
                n_value = i_prev_keep ? i_value : i_prev_value;
                n_valid = r_valid | i_prev_valid;
            end
        end else if (i_ctrl.shift) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end
    end

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Element storage.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

FILE: hdl/heap_sort_engine_core.sv
// ----------------------------------------------------------------------------
// heap_sort_engine_core
// Sorts a set of signed 32-bit elements and returns it in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_ready / i_in_item) takes one element
//   per item; the item with last set closes the set. While a set is being
//   collected an item is taken in every cycle: each element is placed at
//   once into a row of MAX_ELEMENTS cells kept in ascending order, so one
//   compare per cell and a one-place shift of the row settle it.
//   Elements beyond MAX_ELEMENTS are dropped and mark the set as overflowed.
//   The first result is offered in the cycle after the last item is taken.
//   The results then leave one per cycle from the low end of the row
//   (o_out_valid / i_out_ready / o_out_item) while the receiver is ready,
//   the final one flagged with last_res. While results are pending
//   the input channel is not ready; it reopens the cycle after the final
//   result is taken. A stalled receiver simply holds the row and the
//   offered result. Reset empties the row, clears the count and the
//   overflow flag and leaves the engine collecting.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module heap_sort_engine_core
    import hse_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    t_state     r_state;
    t_state     n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic       r_dropped;
    logic       n_dropped;

    logic       in_accept;
    logic       out_accept;
    logic       full;
    t_cell_ctrl cell_ctrl;

    logic                      c_keep  [MAX_ELEMENTS];
    logic                      c_valid [MAX_ELEMENTS];
    logic signed [VALUE_W-1:0] c_value [MAX_ELEMENTS];

    // Handshakes.
    assign o_in_ready  = (r_state == ST_COLLECT);
    assign o_out_valid = (r_state == ST_DRAIN) && c_valid[0];
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_accept  = o_out_valid && i_out_ready;
    assign full        = (r_count == CNT_W'(MAX_ELEMENTS));

    // Row commands.
    assign cell_ctrl.insert = in_accept && !full;
    assign cell_ctrl.shift  = out_accept;

    // Result item taken from the low end of the row.
    assign o_out_item.value_res = c_value[0];
    assign o_out_item.last_res  = !c_valid[1];
    assign o_out_item.overflow  = r_dropped;

    // Row of cells, lowest element at index zero.
    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        logic                      prev_keep;
        logic                      prev_valid;
        logic signed [VALUE_W-1:0] prev_value;
        logic                      next_valid;
        logic signed [VALUE_W-1:0] next_value;

        if (g == 0) begin : g_first
            assign prev_keep  = 1'b1;
            assign prev_valid = 1'b1;
            assign prev_value = '0;
        end else begin : g_inner
            assign prev_keep  = c_keep[g-1];
            assign prev_valid = c_valid[g-1];
            assign prev_value = c_value[g-1];
        end

        if (g == MAX_ELEMENTS - 1) begin : g_end
            assign next_valid = 1'b0;
            assign next_value = '0;
        end else begin : g_mid
            assign next_valid = c_valid[g+1];
            assign next_value = c_value[g+1];
        end

        hse_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (cell_ctrl),
            .i_value      (i_in_item.value),
            .i_prev_keep  (prev_keep),
            .i_prev_valid (prev_valid),
            .i_prev_value (prev_value),
            .i_next_valid (next_valid),
            .i_next_value (next_value),
            .o_keep       (c_keep[g]),
            .o_valid      (c_valid[g]),
            .o_value      (c_value[g])
        );
    end

    // Phase, fill count and overflow flag.
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        unique case (r_state)
            ST_COLLECT: begin
                if (in_accept) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_in_item.last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_accept && o_out_item.last_res) begin
                    n_state   = ST_COLLECT;
                    n_count   = '0;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_COLLECT;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    // Checks on the control logic.
    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_W'(MAX_ELEMENTS))
    `ASSERT_SYNC(a_last_starts_drain, i_clk, i_rst_n,
                 (in_accept && i_in_item.last) |=> o_out_valid)
    `ASSERT_SYNC(a_final_clears, i_clk, i_rst_n,
                 (out_accept && o_out_item.last_res) |=>
                 (o_in_ready && r_count == '0 && !c_valid[0]))
    `ASSERT_NEVER(a_drain_nonempty, i_clk, i_rst_n, (r_state == ST_DRAIN) && !c_valid[0])

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for heap_sort_engine_core. Sets of signed elements are
// sent over the input channel with random gaps. A local heap sort predicts
// the ascending results of each set, including the overflow mark when the
// row's capacity is exceeded. Every result taken from the block is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import hse_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 32;
    localparam int REPORT_LIMIT = 10;
    localparam int TARGET_ITEMS = 230;

    // One pending input item with the idle cycles to wait before it.
    typedef struct {
        t_in_item    item;
        int unsigned gap;
        bit          hold_for_drain;
    } t_send_slot;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    t_send_slot  send_queue[$];
    t_out_item   sorted_expect[$];

    // Local copy of the element row and the set bookkeeping.
    logic signed [VALUE_W-1:0] held [CAPACITY];
    int          held_count   = 0;
    bit          held_dropped = 1'b0;

    bit          in_taken       = 1'b0;
    bit          out_taken      = 1'b0;
    bit          gap_loaded     = 1'b0;
    int unsigned gap_left       = 0;
    bit          rx_armed       = 1'b0;
    bit          rx_calm        = 1'b0;
    int unsigned stall_left     = 0;
    int          accepted_items = 0;
    int          total_items    = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;

    heap_sort_engine_core #(
        .MAX_ELEMENTS(CAPACITY)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    // Clock with a 20 ns period.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Elements biased towards the extremes and towards small, tied values.
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3: return 32'($urandom_range(0, 6)) - 32'd3;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_value(input logic [VALUE_W-1:0] value, input bit last,
                               input int unsigned gap, input bit hold);
        t_send_slot slot;
        slot.item.value     = value;
        slot.item.last      = last;
        slot.gap            = gap;
        slot.hold_for_drain = hold;
        send_queue.push_back(slot);
    endtask

    task automatic queue_set(input int count, input bit calm, input bit hold);
        for (int k = 0; k < count; k++) begin
            queue_value(pick_value(), k == count - 1, calm ? 0 : $urandom_range(0, 19),
                        hold && k == 0);
        end
    endtask

    // Sifts the entry at node down within a heap of n entries.
    function automatic void sift_down_at(input int node, input int n);
        int cur;
        int left;
        int right;
        int big;
        bit done;
        logic signed [VALUE_W-1:0] tmp;
        cur  = node;
        done = 1'b0;
        while (!done) begin
            left  = 2 * cur + 1;
            right = left + 1;
            big   = cur;
            if (left < n && held[left] > held[big]) big = left;
            if (right < n && held[right] > held[big]) big = right;
            if (big == cur) begin
                done = 1'b1;
            end else begin
                tmp       = held[cur];
                held[cur] = held[big];
                held[big] = tmp;
                cur       = big;
            end
        end
    endfunction

    // Stores an accepted element; on the last one, sorts the set and queues
    // the ascending results.
    task automatic absorb_element(input t_in_item it);
        t_out_item res;
        int n;
        logic signed [VALUE_W-1:0] tmp;
        if (held_count < CAPACITY) begin
            held[held_count] = it.value;
            held_count++;
        end else begin
            held_dropped = 1'b1;
        end
        if (it.last) begin
            n = held_count;
            for (int i = n / 2; i > 0; i--) sift_down_at(i - 1, n);
            for (int i = n - 1; i > 0; i--) begin
                tmp     = held[0];
                held[0] = held[i];
                held[i] = tmp;
                sift_down_at(0, i);
            end
            for (int k = 0; k < n; k++) begin
                res.value_res = held[k];
                res.last_res  = (k == n - 1);
                res.overflow  = held_dropped;
                sorted_expect.push_back(res);
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endtask

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    endtask

    // Input driver: waits out each item's gap, and for the results to drain
    // where an item asks for it, then holds the item until it is taken.
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_taken) begin
                // Item still on offer; leave it untouched.
            end else if (send_queue.size() == 0) begin
                in_valid <= 1'b0;
            end else begin
                if (!gap_loaded) begin
                    gap_left   = send_queue[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left != 0 ||
                    (send_queue[0].hold_for_drain && sorted_expect.size() != 0)) begin
                    if (gap_left != 0) gap_left--;
                    in_valid <= 1'b0;
                end else begin
                    in_item    <= send_queue[0].item;
                    in_valid   <= 1'b1;
                    gap_loaded = 1'b0;
                    void'(send_queue.pop_front());
                end
            end
        end
    end

    // Result receiver: draws a stall for each offered result.
    always @(negedge clk) begin
        if (rst_n) begin
            if (out_taken) rx_armed = 1'b0;
            if (!rx_armed && out_valid) begin
                rx_armed   = 1'b1;
                stall_left = rx_calm ? 0 : $urandom_range(0, 19);
            end
            if (stall_left != 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= out_valid ? 1'b1 : 1'($urandom_range(0, 1));
            end
        end
    end

    // Monitor: feeds accepted items to the predictor before checking results,
    // so a prediction is always in place when its result is seen.
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken  <= in_valid && in_ready;
            out_taken <= out_valid && out_ready;
            if (in_valid && in_ready) begin
                absorb_element(in_item);
                accepted_items++;
            end
            if (out_valid && out_ready) begin
                if (sorted_expect.size() == 0) begin
                    note_failure($sformatf("unexpected result value=%0d last=%0b ovf=%0b",
                                           out_item.value_res, out_item.last_res,
                                           out_item.overflow));
                end else begin
                    want = sorted_expect.pop_front();
                    if (out_item.value_res !== want.value_res ||
                        out_item.last_res !== want.last_res ||
                        out_item.overflow !== want.overflow) begin
                        note_failure($sformatf({"result expected value=%0d last=%0b ovf=%0b,",
                                                " got value=%0d last=%0b ovf=%0b"},
                                               want.value_res, want.last_res, want.overflow,
                                               out_item.value_res, out_item.last_res,
                                               out_item.overflow));
                    end
                end
                if (out_item.last_res) rx_calm = ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Watchdog.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        // Single-element sets at both extremes.
        queue_value(32'h7fff_ffff, 1'b1, 0, 1'b0);
        queue_value(32'h8000_0000, 1'b1, 3, 1'b0);
        // Extremes and values around zero in one set.
        queue_value(32'd0, 1'b0, 0, 1'b0);
        queue_value(32'hffff_ffff, 1'b0, 0, 1'b0);
        queue_value(32'd1, 1'b0, 2, 1'b0);
        queue_value(32'h8000_0000, 1'b0, 0, 1'b0);
        queue_value(32'h7fff_ffff, 1'b1, 0, 1'b0);
        // Ties.
        queue_value(32'd5, 1'b0, 0, 1'b0);
        queue_value(32'd5, 1'b0, 1, 1'b0);
        queue_value(-32'sd5, 1'b0, 0, 1'b0);
        queue_value(32'd5, 1'b1, 0, 1'b0);
        // Descending run, sent only once the earlier results have all come.
        for (int k = 0; k < 6; k++) begin
            queue_value(32'(4 - k), k == 5, 0, k == 0);
        end
        // Ascending run.
        for (int k = 0; k < 3; k++) begin
            queue_value(32'(k * 1000 - 1000), k == 2, 1, 1'b0);
        end

        // Random sets: mostly small, one that fills the row exactly and one
        // that overruns it, dropping the final element too.
        while (send_queue.size() < 110) begin
            queue_set($urandom_range(1, 10), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 7) == 0);
        end
        queue_set(CAPACITY, $urandom_range(0, 1), 1'b0);
        queue_set(CAPACITY + 3, $urandom_range(0, 1), 1'b1);
        while (send_queue.size() < TARGET_ITEMS) begin
            queue_set($urandom_range(1, 10), $urandom_range(0, 3) == 0,
                      $urandom_range(0, 7) == 0);
        end
        total_items = send_queue.size();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_items < total_items || sorted_expect.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        mismatch_count += sorted_expect.size();

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/hse_pkg.sv
hdl/hse_cell.sv
hdl/heap_sort_engine_core.sv
bench/testbench.sv
